>>> hdl/oeps_pkg.sv
// Package for the One Euro point smoother: field widths, fixed-point constants,
// datapath operation codes and the controller/datapath command and status types.
// No dependencies.
package oeps_pkg;

  localparam logic       CMD_FILTER = 1'b0;
  localparam logic       CMD_RESET  = 1'b1;

  localparam logic [1:0] CFG_MIN_CUTOFF = 2'd0;
  localparam logic [1:0] CFG_SPEED_GAIN = 2'd1;
  localparam logic [1:0] CFG_VEL_CUTOFF = 2'd2;

  localparam logic [23:0] CUTOFF_RESET = 24'h010000;
  localparam logic [23:0] GAIN_RESET   = 24'h000000;

  localparam logic [48:0] HALF_TURN_SCALE = 49'd10430378350;
  localparam logic [19:0] US_PER_S        = 20'd1000000;

  localparam int          CNT_W       = 6;
  localparam logic [5:0]  ALPHA_STEPS = 6'd16;
  localparam logic [5:0]  RAW_STEPS   = 6'd46;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_BYPASS,
    OP_READ,
    OP_VMUL,
    OP_DIV_ALPHA,
    OP_DIV_RAW,
    OP_DIV_STEP,
    OP_RMUL,
    OP_BMUL,
    OP_VUPD,
    OP_GMUL,
    OP_CUT,
    OP_PMUL,
    OP_PBMUL,
    OP_PBLEND,
    OP_WRITE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   axis;
    logic   take;
  } dp_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic is_reset;
    logic bypass;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/oeps_if.sv
// Channel interfaces of the One Euro point smoother: point input, filtered
// output and configuration write. No dependencies.
interface oeps_pt_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [4:0]         point_index;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [47:0]        frame_time_us;
  logic               last_in_frame;
  modport source (output valid, command, point_index, point_x, point_y, frame_time_us,
                  last_in_frame, input ready);
  modport sink (input valid, command, point_index, point_x, point_y, frame_time_us,
                last_in_frame, output ready);
endinterface

interface oeps_pt_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         out_index;
  logic signed [23:0] filtered_x;
  logic signed [23:0] filtered_y;
  logic               frame_done;
  modport source (output valid, out_index, filtered_x, filtered_y, frame_done, input ready);
  modport sink (input valid, out_index, filtered_x, filtered_y, frame_done, output ready);
endinterface

interface oeps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/oeps_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module oeps_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

>>> hdl/oeps_ctrl.sv
// Sequencer of the One Euro point smoother: steps the datapath through one point.
// Depends on oeps_pkg.
module oeps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oeps_pkg::dp_sts_t sts_i,
  output oeps_pkg::dp_cmd_t cmd_o
);
  import oeps_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_DECIDE = 19'h00002,
    ST_VMUL   = 19'h00004,
    ST_VDIVLD = 19'h00008,
    ST_VDIV   = 19'h00010,
    ST_RMUL   = 19'h00020,
    ST_RDIVLD = 19'h00040,
    ST_RDIV   = 19'h00080,
    ST_BMUL   = 19'h00100,
    ST_VUPD   = 19'h00200,
    ST_GMUL   = 19'h00400,
    ST_CUT    = 19'h00800,
    ST_PMUL   = 19'h01000,
    ST_PDIVLD = 19'h02000,
    ST_PDIV   = 19'h04000,
    ST_PBMUL  = 19'h08000,
    ST_PBLEND = 19'h10000,
    ST_WRITE  = 19'h20000,
    ST_EMIT   = 19'h40000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    cmd_o.op    = OP_NONE;
    cmd_o.take  = 1'b0;
    cmd_o.axis  = axis_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_fire) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        axis_d = 1'b0;
        if (sts_i.is_reset) begin
          cmd_o.op = OP_CLEAR;
          state_d  = ST_IDLE;
        end else if (sts_i.bypass) begin
          cmd_o.op = OP_BYPASS;
          state_d  = ST_EMIT;
        end else begin
          cmd_o.op = OP_READ;
          state_d  = ST_VMUL;
        end
      end
      ST_VMUL: begin
        cmd_o.op = OP_VMUL;
        state_d  = ST_VDIVLD;
      end
      ST_VDIVLD: begin
        cmd_o.op = OP_DIV_ALPHA;
        cnt_d    = ALPHA_STEPS - 6'd1;
        state_d  = ST_VDIV;
      end
      ST_VDIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = ST_RMUL;
      end
      ST_RMUL: begin
        cmd_o.op = OP_RMUL;
        state_d  = ST_RDIVLD;
      end
      ST_RDIVLD: begin
        cmd_o.op = OP_DIV_RAW;
        cnt_d    = RAW_STEPS - 6'd1;
        state_d  = ST_RDIV;
      end
      ST_RDIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = ST_BMUL;
      end
      ST_BMUL: begin
        cmd_o.op = OP_BMUL;
        state_d  = ST_VUPD;
      end
      ST_VUPD: begin
        cmd_o.op = OP_VUPD;
        state_d  = ST_GMUL;
      end
      ST_GMUL: begin
        cmd_o.op = OP_GMUL;
        state_d  = ST_CUT;
      end
      ST_CUT: begin
        cmd_o.op = OP_CUT;
        state_d  = ST_PMUL;
      end
      ST_PMUL: begin
        cmd_o.op = OP_PMUL;
        state_d  = ST_PDIVLD;
      end
      ST_PDIVLD: begin
        cmd_o.op = OP_DIV_ALPHA;
        cnt_d    = ALPHA_STEPS - 6'd1;
        state_d  = ST_PDIV;
      end
      ST_PDIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = ST_PBMUL;
      end
      ST_PBMUL: begin
        cmd_o.op = OP_PBMUL;
        state_d  = ST_PBLEND;
      end
      ST_PBLEND: begin
        cmd_o.op = OP_PBLEND;
        if (axis_q) begin
          state_d = ST_WRITE;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_RMUL;
        end
      end
      ST_WRITE: begin
        cmd_o.op = OP_WRITE;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

>>> hdl/oeps_dp.sv
// Datapath of the One Euro point smoother: config registers, frame state,
// multipliers with a shared product register, restoring divider, per-point store
// and output register. Depends on oeps_pkg, oeps_if, oeps_ram.
module oeps_dp #(
  parameter int MAX_POINTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oeps_pkg::dp_cmd_t cmd_i,
  output oeps_pkg::dp_sts_t sts_o,
  oeps_pt_in_if.sink        pt_in,
  oeps_pt_out_if.source     pt_out,
  oeps_cfg_if.sink          cfg_wr
);
  import oeps_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [23:0]        min_cut_q, gain_q, vcut_q;
  logic               primed_q, seeding_q;
  logic [47:0]        prev_time_q;

  logic               cmd_q;
  logic [4:0]         idx_q;
  logic signed [23:0] x_q, y_q;
  logic [47:0]        now_q;
  logic               last_q;

  logic [47:0]        dt_q;
  logic signed [23:0] prev_x_q, prev_y_q;
  logic signed [31:0] vel_x_q, vel_y_q;
  logic [62:0]        prod_q;
  logic               neg_q;
  logic [48:0]        rem_q, den_q;
  logic [45:0]        dvd_q, quot_q;
  logic [15:0]        alpha_v_q;
  logic [23:0]        cut_q;

  logic               out_valid_q, out_last_q;
  logic [4:0]         out_idx_q;
  logic signed [23:0] out_x_q, out_y_q;

  logic               in_fire, idx_valid, seed_eff;
  logic [23:0]        dcap;
  logic signed [23:0] xs, ps;
  logic signed [31:0] vs;
  logic signed [24:0] delta;
  logic [24:0]        dmag_p;
  logic [44:0]        rmul_p;
  logic signed [47:0] raw, diff;
  logic [46:0]        dmag_v;
  logic [62:0]        bmul_p;
  logic [46:0]        pv;
  logic signed [48:0] vsum;
  logic signed [31:0] vnew;
  logic [31:0]        speed;
  logic [55:0]        gmul_p;
  logic [46:0]        csum;
  logic [47:0]        fd_v, fd_p;
  logic [40:0]        pbmul_p;
  logic [24:0]        pp;
  logic signed [25:0] rsum;
  logic [49:0]        rem_sh;
  logic               ge;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_addr;
  logic [111:0]       ram_wdata, ram_rdata;

  assign cfg_wr.ready = 1'b1;
  assign pt_in.ready  = cmd_i.take;
  assign in_fire      = pt_in.valid & cmd_i.take;

  assign idx_valid = (32'(idx_q) < MAX_POINTS);
  assign seed_eff  = seeding_q | ~primed_q;

  assign sts_o.in_fire  = in_fire;
  assign sts_o.is_reset = (cmd_q == CMD_RESET);
  assign sts_o.bypass   = ~idx_valid | seed_eff;
  assign sts_o.out_free = ~out_valid_q | pt_out.ready;

  assign dcap = (|dt_q[47:24]) ? 24'hFFFFFF : dt_q[23:0];
  assign xs   = cmd_i.axis ? y_q : x_q;
  assign ps   = cmd_i.axis ? prev_y_q : prev_x_q;
  assign vs   = cmd_i.axis ? vel_y_q : vel_x_q;

  assign delta   = {xs[23], xs} - {ps[23], ps};
  assign dmag_p  = delta[24] ? 25'(-delta) : 25'(delta);
  assign rmul_p  = dmag_p * US_PER_S;
  assign pbmul_p = dmag_p * quot_q[15:0];

  assign raw    = neg_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
  assign diff   = raw - 48'(vs);
  assign dmag_v = diff[47] ? 47'(-diff) : 47'(diff);
  assign bmul_p = dmag_v * alpha_v_q;

  assign pv   = 47'((prod_q + 63'd32768) >> 16);
  assign vsum = neg_q ? 49'(vs) - $signed({2'b00, pv}) : 49'(vs) + $signed({2'b00, pv});

  always_comb begin
    if (vsum > $signed(49'h0_7FFF_FFFF)) begin
      vnew = 32'sh7FFFFFFF;
    end else if (vsum < -$signed(49'h0_8000_0000)) begin
      vnew = 32'sh80000000;
    end else begin
      vnew = 32'(vsum);
    end
  end

  assign speed  = vs[31] ? 32'(-vs) : 32'(vs);
  assign gmul_p = gain_q * speed;
  assign csum   = 47'(min_cut_q) + 47'(prod_q[55:10]);
  assign fd_v   = vcut_q * dcap;
  assign fd_p   = cut_q * dcap;

  assign pp   = 25'((prod_q[40:0] + 41'd32768) >> 16);
  assign rsum = neg_q ? 26'(ps) - $signed({1'b0, pp}) : 26'(ps) + $signed({1'b0, pp});

  assign rem_sh = {rem_q, dvd_q[45]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  assign ram_addr = AW'(idx_q);
  assign ram_re   = (cmd_i.op == OP_READ);
  assign ram_we   = ((cmd_i.op == OP_BYPASS) && seed_eff && idx_valid) ||
                    (cmd_i.op == OP_WRITE);
  assign ram_wdata = (cmd_i.op == OP_BYPASS) ? {x_q, y_q, 64'd0}
                                             : {prev_x_q, prev_y_q, vel_x_q, vel_y_q};

  oeps_ram #(
    .WIDTH (112),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cut_q <= CUTOFF_RESET;
      gain_q    <= GAIN_RESET;
      vcut_q    <= CUTOFF_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_MIN_CUTOFF: min_cut_q <= cfg_wr.data;
        CFG_SPEED_GAIN: gain_q    <= cfg_wr.data;
        CFG_VEL_CUTOFF: vcut_q    <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      seeding_q   <= 1'b0;
      prev_time_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_CLEAR: begin
          primed_q    <= 1'b0;
          seeding_q   <= 1'b0;
          prev_time_q <= '0;
        end
        OP_BYPASS: begin
          primed_q <= 1'b1;
          if (!primed_q) seeding_q <= 1'b1;
          if (last_q) begin
            prev_time_q <= now_q;
            seeding_q   <= 1'b0;
          end
        end
        OP_WRITE: begin
          if (last_q) begin
            prev_time_q <= now_q;
            seeding_q   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= pt_in.command;
      idx_q  <= pt_in.point_index;
      x_q    <= pt_in.point_x;
      y_q    <= pt_in.point_y;
      now_q  <= pt_in.frame_time_us;
      last_q <= pt_in.last_in_frame;
    end
    case (cmd_i.op)
      OP_BYPASS: begin
        prev_x_q <= x_q;
        prev_y_q <= y_q;
      end
      OP_READ: begin
        dt_q <= (now_q > prev_time_q) ? now_q - prev_time_q : 48'd1;
      end
      OP_VMUL: begin
        prev_x_q <= ram_rdata[111:88];
        prev_y_q <= ram_rdata[87:64];
        vel_x_q  <= ram_rdata[63:32];
        vel_y_q  <= ram_rdata[31:0];
        prod_q   <= 63'(fd_v);
      end
      OP_DIV_ALPHA: begin
        rem_q  <= 49'(prod_q[47:0]);
        den_q  <= 49'(prod_q[47:0]) + HALF_TURN_SCALE;
        dvd_q  <= '0;
        quot_q <= '0;
      end
      OP_DIV_RAW: begin
        rem_q  <= '0;
        den_q  <= 49'(dt_q);
        dvd_q  <= prod_q[45:0];
        quot_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= ge ? 49'(rem_sh - {1'b0, den_q}) : rem_sh[48:0];
        dvd_q  <= {dvd_q[44:0], 1'b0};
        quot_q <= {quot_q[44:0], ge};
      end
      OP_RMUL: begin
        if (!cmd_i.axis) alpha_v_q <= quot_q[15:0];
        prod_q <= 63'(rmul_p);
        neg_q  <= delta[24];
      end
      OP_BMUL: begin
        prod_q <= bmul_p;
        neg_q  <= diff[47];
      end
      OP_VUPD: begin
        if (cmd_i.axis) vel_y_q <= vnew;
        else            vel_x_q <= vnew;
      end
      OP_GMUL: begin
        prod_q <= 63'(gmul_p);
      end
      OP_CUT: begin
        cut_q <= (|csum[46:24]) ? 24'hFFFFFF : csum[23:0];
      end
      OP_PMUL: begin
        prod_q <= 63'(fd_p);
      end
      OP_PBMUL: begin
        prod_q <= 63'(pbmul_p);
        neg_q  <= delta[24];
      end
      OP_PBLEND: begin
        if (cmd_i.axis) prev_y_q <= rsum[23:0];
        else            prev_x_q <= rsum[23:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (pt_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_idx_q  <= idx_q;
      out_x_q    <= prev_x_q;
      out_y_q    <= prev_y_q;
      out_last_q <= last_q;
    end
  end

  assign pt_out.valid      = out_valid_q;
  assign pt_out.out_index  = out_idx_q;
  assign pt_out.filtered_x = out_x_q;
  assign pt_out.filtered_y = out_y_q;
  assign pt_out.frame_done = out_last_q;
endmodule

>>> hdl/one_euro_point_smoother.sv
// One Euro point smoother, top level: sequencer plus datapath.
// A filtered point runs through the shared one-bit-per-cycle divider
// (16 + 2 x (46 + 16) steps); a passed-through point skips it. The sequencer takes
// one transaction at a time; a reset command gives no result, and a stalled output
// holds the sequencer. Asynchronous reset clears control and frame state, loads
// register defaults; the per-point store is not cleared.
module one_euro_point_smoother #(
  parameter int MAX_POINTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  oeps_pt_in_if.sink    pt_in,
  oeps_pt_out_if.source pt_out,
  oeps_cfg_if.sink      cfg_wr
);
  import oeps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  oeps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oeps_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .pt_in  (pt_in),
    .pt_out (pt_out),
    .cfg_wr (cfg_wr)
  );
endmodule
